@@ design/assert_macros.svh @@
// assertion macros used by the scheduler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/edf_pkg.sv @@
// types, constants and codes of the edf task scheduler
package edf_pkg;

    localparam int ACTIVE_DEPTH    = 8;
    localparam int APERIODIC_DEPTH = 4;
    localparam int AW  = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam int CW  = $clog2(ACTIVE_DEPTH + 1);
    localparam int AAW = (APERIODIC_DEPTH > 1) ? $clog2(APERIODIC_DEPTH) : 1;
    localparam int ACW = $clog2(APERIODIC_DEPTH + 1);

    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_POLL   = 2'd2;

    localparam logic [1:0] KIND_OVERDUE  = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;

    localparam logic [2:0] LIMIT_RESET = 3'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  task_id;
        logic [31:0] rel_deadline;
        logic        del_aperiodic;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  task_id_res;
        logic        is_aperiodic;
        logic        rejected;
        logic [3:0]  active_count;
        logic [2:0]  aperiodic_count;
        logic [15:0] overdue_total;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  id;
    } act_entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_OP,
        S_INS_RD,
        S_INS_CHK,
        S_DEL_RD,
        S_DEL_CHK,
        S_SH_RD,
        S_SH_WR,
        S_AD_RD,
        S_AD_CHK,
        S_AS_RD,
        S_AS_WR,
        S_SC_RD,
        S_SC_CHK,
        S_EM_RD,
        S_EM_LD,
        S_EM_WAIT
    } state_t;

endpackage

@@ design/edf_task_scheduler.sv @@
// edf task scheduler top level: sequencer over the periodic and aperiodic memories
//
//  channel   signals                     direction  carries
//  in        in_valid in_ready in_data   input      one create, delete or poll request
//  out       out_valid out_ready out_data output    overdue, dispatch and none results
//  cfg       cfg_valid cfg_ready cfg_data input     aperiodic limit
//
// insert, delete and the overdue scan walk the table one entry at a time, each
// reading a memory entry and comparing it in the next cycle; each result passes
// S_EM_RD, S_EM_LD and S_EM_WAIT, and S_SH_RD/S_SH_WR shift entries after a
// delete or overdue removal; one request at a time; in_ready is high only
// between requests; reset clears the counts, so no memory clearing pass is needed
`include "assert_macros.svh"

module edf_task_scheduler (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  edf_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output edf_pkg::res_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_data
);

    import edf_pkg::*;

    state_t      state_reg, state_next;
    req_t        req_reg, req_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  off_reg, off_next;
    logic [CW-1:0]  m_reg, m_next;
    logic [ACW-1:0] acnt_reg, acnt_next;
    logic [15:0] ovd_reg, ovd_next;
    logic [2:0]  limit_reg;
    logic [31:0] dl_reg, dl_next;
    logic        rej_reg, rej_next;
    logic        shfin_reg, shfin_next;
    logic [1:0]  kind_reg, kind_next;
    logic        aper_reg, aper_next;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;

    logic        a_we, a_re;
    logic [AW-1:0] a_waddr, a_raddr;
    act_entry_t  a_wdata, a_rdata;
    logic        p_we, p_re;
    logic [AAW-1:0] p_waddr, p_raddr;
    logic [7:0]  p_wdata, p_rdata;

    logic [CW:0] src;
    logic [16:0] ovd_sum;
    logic        aper_full;

    edf_ram #(.WIDTH(40), .DEPTH(ACTIVE_DEPTH)) u_active_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    edf_ram #(.WIDTH(8), .DEPTH(APERIODIC_DEPTH)) u_aper_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign src       = {1'b0, idx_reg} + {1'b0, off_reg};
    assign ovd_sum   = 17'(ovd_reg) + 17'(idx_reg);
    assign aper_full = (int'(acnt_reg) >= int'(limit_reg)) ||
                       (int'(acnt_reg) >= APERIODIC_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            acnt_reg      <= '0;
            ovd_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            acnt_reg      <= acnt_next;
            ovd_reg       <= ovd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        off_reg   <= off_next;
        m_reg     <= m_next;
        dl_reg    <= dl_next;
        rej_reg   <= rej_next;
        shfin_reg <= shfin_next;
        kind_reg  <= kind_next;
        aper_reg  <= aper_next;
        out_reg   <= out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                case (req_reg.func)
                    FUNC_CREATE:
                    begin
                        if (req_reg.rel_deadline != '0 && int'(n_reg) < ACTIVE_DEPTH)
                        begin
                            state_next = S_INS_RD;
                        end
                        else
                        begin
                            state_next = S_SC_RD;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        state_next = req_reg.del_aperiodic ? S_AD_RD : S_DEL_RD;
                    end
                    default:
                    begin
                        state_next = S_SC_RD;
                    end
                endcase
            end
            S_INS_RD:
            begin
                state_next = (idx_reg == '0) ? S_SC_RD : S_INS_CHK;
            end
            S_INS_CHK:
            begin
                state_next = (a_rdata.deadline > dl_reg) ? S_INS_RD : S_SC_RD;
            end
            S_DEL_RD:
            begin
                state_next = (idx_reg == n_reg) ? S_SC_RD : S_DEL_CHK;
            end
            S_DEL_CHK:
            begin
                state_next = (a_rdata.id == req_reg.task_id) ? S_SH_RD : S_DEL_RD;
            end
            S_SH_RD:
            begin
                if (src >= {1'b0, n_reg})
                begin
                    state_next = shfin_reg ? S_IDLE : S_SC_RD;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                state_next = S_SH_RD;
            end
            S_AD_RD:
            begin
                state_next = (int'(idx_reg) == int'(acnt_reg)) ? S_SC_RD : S_AD_CHK;
            end
            S_AD_CHK:
            begin
                state_next = (p_rdata == req_reg.task_id) ? S_AS_RD : S_AD_RD;
            end
            S_AS_RD:
            begin
                state_next = (int'(idx_reg) + 1 >= int'(acnt_reg)) ? S_SC_RD : S_AS_WR;
            end
            S_AS_WR:
            begin
                state_next = S_AS_RD;
            end
            S_SC_RD:
            begin
                state_next = (idx_reg == n_reg) ? S_EM_RD : S_SC_CHK;
            end
            S_SC_CHK:
            begin
                state_next = (a_rdata.deadline < req_reg.now) ? S_SC_RD : S_EM_RD;
            end
            S_EM_RD:
            begin
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                state_next = S_EM_WAIT;
            end
            S_EM_WAIT:
            begin
                if (out_ready)
                begin
                    if (kind_reg == KIND_OVERDUE)
                    begin
                        state_next = S_EM_RD;
                    end
                    else
                    begin
                        state_next = (m_reg != '0) ? S_SH_RD : S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        req_next       = req_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        m_next         = m_reg;
        acnt_next      = acnt_reg;
        ovd_next       = ovd_reg;
        dl_next        = dl_reg;
        rej_next       = rej_reg;
        shfin_next     = shfin_reg;
        kind_next      = kind_reg;
        aper_next      = aper_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        a_we    = 1'b0;
        a_waddr = idx_reg[AW-1:0];
        a_wdata = '{deadline: dl_reg, id: req_reg.task_id};
        a_re    = 1'b0;
        a_raddr = idx_reg[AW-1:0];
        p_we    = 1'b0;
        p_waddr = idx_reg[AAW-1:0];
        p_wdata = p_rdata;
        p_re    = 1'b0;
        p_raddr = idx_reg[AAW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                    rej_next = 1'b0;
                end
            end
            S_OP:
            begin
                idx_next = '0;
                case (req_reg.func)
                    FUNC_CREATE:
                    begin
                        if (req_reg.rel_deadline == '0)
                        begin
                            if (aper_full)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                p_we      = 1'b1;
                                p_waddr   = acnt_reg[AAW-1:0];
                                p_wdata   = req_reg.task_id;
                                acnt_next = acnt_reg + ACW'(1);
                            end
                        end
                        else if (int'(n_reg) >= ACTIVE_DEPTH)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            dl_next  = req_reg.now + req_reg.rel_deadline;
                            idx_next = n_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    a_we   = 1'b1;
                    n_next = n_reg + CW'(1);
                end
                else
                begin
                    a_re    = 1'b1;
                    a_raddr = AW'(idx_reg - CW'(1));
                end
            end
            S_INS_CHK:
            begin
                a_we = 1'b1;
                if (a_rdata.deadline > dl_reg)
                begin
                    a_wdata  = a_rdata;
                    idx_next = idx_reg - CW'(1);
                end
                else
                begin
                    n_next   = n_reg + CW'(1);
                    idx_next = '0;
                end
            end
            S_DEL_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    idx_next = '0;
                end
                else
                begin
                    a_re = 1'b1;
                end
            end
            S_DEL_CHK:
            begin
                if (a_rdata.id == req_reg.task_id)
                begin
                    off_next   = CW'(1);
                    shfin_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_SH_RD:
            begin
                if (src >= {1'b0, n_reg})
                begin
                    n_next   = n_reg - off_reg;
                    idx_next = '0;
                end
                else
                begin
                    a_re    = 1'b1;
                    a_raddr = src[AW-1:0];
                end
            end
            S_SH_WR:
            begin
                a_we     = 1'b1;
                a_wdata  = a_rdata;
                idx_next = idx_reg + CW'(1);
            end
            S_AD_RD:
            begin
                if (int'(idx_reg) == int'(acnt_reg))
                begin
                    idx_next = '0;
                end
                else
                begin
                    p_re = 1'b1;
                end
            end
            S_AD_CHK:
            begin
                if (p_rdata != req_reg.task_id)
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_AS_RD:
            begin
                if (int'(idx_reg) + 1 >= int'(acnt_reg))
                begin
                    acnt_next = acnt_reg - ACW'(1);
                    idx_next  = '0;
                end
                else
                begin
                    p_re    = 1'b1;
                    p_raddr = AAW'(idx_reg + CW'(1));
                end
            end
            S_AS_WR:
            begin
                p_we     = 1'b1;
                p_wdata  = p_rdata;
                idx_next = idx_reg + CW'(1);
            end
            S_SC_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    m_next   = idx_reg;
                    ovd_next = ovd_sum[16] ? 16'hFFFF : ovd_sum[15:0];
                    idx_next = '0;
                end
                else
                begin
                    a_re = 1'b1;
                end
            end
            S_SC_CHK:
            begin
                if (a_rdata.deadline < req_reg.now)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    m_next   = idx_reg;
                    ovd_next = ovd_sum[16] ? 16'hFFFF : ovd_sum[15:0];
                    idx_next = '0;
                end
            end
            S_EM_RD:
            begin
                aper_next = 1'b0;
                if (idx_reg < m_reg)
                begin
                    a_re      = 1'b1;
                    kind_next = KIND_OVERDUE;
                end
                else if (n_reg > m_reg)
                begin
                    a_re      = 1'b1;
                    kind_next = KIND_DISPATCH;
                end
                else if (acnt_reg != '0)
                begin
                    p_re      = 1'b1;
                    p_raddr   = '0;
                    kind_next = KIND_DISPATCH;
                    aper_next = 1'b1;
                end
                else
                begin
                    kind_next = KIND_NONE;
                end
            end
            S_EM_LD:
            begin
                out_valid_next           = 1'b1;
                out_next.kind            = kind_reg;
                out_next.is_aperiodic    = aper_reg;
                out_next.rejected        = rej_reg;
                out_next.active_count    = 4'(n_reg - m_reg);
                out_next.aperiodic_count = 3'(acnt_reg);
                out_next.overdue_total   = ovd_reg;
                out_next.last            = (kind_reg != KIND_OVERDUE);
                if (kind_reg == KIND_NONE)
                begin
                    out_next.task_id_res = '0;
                end
                else if (aper_reg)
                begin
                    out_next.task_id_res = p_rdata;
                end
                else
                begin
                    out_next.task_id_res = a_rdata.id;
                end
            end
            S_EM_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (kind_reg == KIND_OVERDUE)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                    else
                    begin
                        idx_next   = '0;
                        off_next   = m_reg;
                        shfin_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_CLK(a_active_bound, int'(n_reg) <= ACTIVE_DEPTH, "periodic count out of range")
    `ASSERT_CLK(a_aper_bound, int'(acnt_reg) <= APERIODIC_DEPTH, "aperiodic count out of range")
    `ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid_reg), "request taken while result pending")
    `ASSERT_CLK(a_ovd_mono, 1'b1 |=> ovd_reg >= $past(ovd_reg), "overdue total went down")
    `ASSERT_CLK(a_last_ends, out_valid_reg && out_ready && out_reg.last |=>
        (state_reg == S_IDLE || state_reg == S_SH_RD), "request did not end after last result")

endmodule

@@ design/edf_ram.sv @@
// generic single write port ram with registered read
module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                            clk,
    input  logic                                            we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
    input  logic [WIDTH-1:0]                                wdata,
    input  logic                                            re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
    output logic [WIDTH-1:0]                                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the edf task scheduler with a scoreboard class
module tb;
    import edf_pkg::*;

    class sched_scoreboard;
        logic [31:0] table_dl[ACTIVE_DEPTH];
        logic [7:0]  table_id[ACTIVE_DEPTH];
        int          table_n;
        logic [7:0]  fifo_id[APERIODIC_DEPTH];
        int          fifo_n;
        int          overdue_cnt;
        logic [2:0]  aper_limit;
        res_t        expected_res[$];
        int          errors;
        int          results;

        function new();
            table_n     = 0;
            fifo_n      = 0;
            overdue_cnt = 0;
            aper_limit  = LIMIT_RESET;
            errors      = 0;
            results     = 0;
        endfunction

        function void set_limit(logic [2:0] v);
            aper_limit = v;
        endfunction

        function void drop_entry(int pos);
            for (int i = pos; i + 1 < table_n; i++)
            begin
                table_dl[i] = table_dl[i + 1];
                table_id[i] = table_id[i + 1];
            end
            table_n--;
        endfunction

        function void note_request(req_t r);
            res_t        batch[$];
            res_t        x;
            logic        rej;
            logic [31:0] dl;
            int          lim;
            int          pos;
            rej = 1'b0;
            if (r.func == FUNC_CREATE)
            begin
                if (r.rel_deadline == 0)
                begin
                    lim = (aper_limit < APERIODIC_DEPTH) ? aper_limit : APERIODIC_DEPTH;
                    if (fifo_n >= lim)
                        rej = 1'b1;
                    else
                    begin
                        fifo_id[fifo_n] = r.task_id;
                        fifo_n++;
                    end
                end
                else if (table_n >= ACTIVE_DEPTH)
                    rej = 1'b1;
                else
                begin
                    dl  = r.now + r.rel_deadline;
                    pos = table_n;
                    while (pos > 0 && table_dl[pos - 1] > dl)
                    begin
                        table_dl[pos] = table_dl[pos - 1];
                        table_id[pos] = table_id[pos - 1];
                        pos--;
                    end
                    table_dl[pos] = dl;
                    table_id[pos] = r.task_id;
                    table_n++;
                end
            end
            else if (r.func == FUNC_DELETE)
            begin
                if (r.del_aperiodic)
                begin
                    for (int i = 0; i < fifo_n; i++)
                        if (fifo_id[i] == r.task_id)
                        begin
                            for (int j = i; j + 1 < fifo_n; j++)
                                fifo_id[j] = fifo_id[j + 1];
                            fifo_n--;
                            break;
                        end
                end
                else
                begin
                    for (int i = 0; i < table_n; i++)
                        if (table_id[i] == r.task_id)
                        begin
                            drop_entry(i);
                            break;
                        end
                end
            end
            while (table_n > 0 && table_dl[0] < r.now)
            begin
                x = '0;
                x.kind = KIND_OVERDUE;
                x.task_id_res = table_id[0];
                batch.push_back(x);
                drop_entry(0);
                if (overdue_cnt < 65535)
                    overdue_cnt++;
            end
            x = '0;
            x.last = 1'b1;
            if (table_n > 0)
            begin
                x.kind = KIND_DISPATCH;
                x.task_id_res = table_id[0];
            end
            else if (fifo_n > 0)
            begin
                x.kind = KIND_DISPATCH;
                x.task_id_res = fifo_id[0];
                x.is_aperiodic = 1'b1;
            end
            else
                x.kind = KIND_NONE;
            batch.push_back(x);
            foreach (batch[k])
            begin
                batch[k].rejected        = rej;
                batch[k].active_count    = 4'(table_n);
                batch[k].aperiodic_count = 3'(fifo_n);
                batch[k].overdue_total   = 16'(overdue_cnt);
                expected_res.push_back(batch[k]);
            end
        endfunction

        function void check_result(res_t got);
            res_t e;
            results++;
            if (expected_res.size() == 0)
            begin
                $error("unexpected result kind %0d id %0d", got.kind, got.task_id_res);
                errors++;
                return;
            end
            e = expected_res.pop_front();
            if (got.kind !== e.kind)
            begin
                $error("kind exp %0d got %0d", e.kind, got.kind);
                errors++;
            end
            if (got.task_id_res !== e.task_id_res)
            begin
                $error("task_id_res exp %0d got %0d", e.task_id_res, got.task_id_res);
                errors++;
            end
            if (got.is_aperiodic !== e.is_aperiodic)
            begin
                $error("is_aperiodic exp %0d got %0d", e.is_aperiodic, got.is_aperiodic);
                errors++;
            end
            if (got.rejected !== e.rejected)
            begin
                $error("rejected exp %0d got %0d", e.rejected, got.rejected);
                errors++;
            end
            if (got.active_count !== e.active_count)
            begin
                $error("active_count exp %0d got %0d", e.active_count, got.active_count);
                errors++;
            end
            if (got.aperiodic_count !== e.aperiodic_count)
            begin
                $error("aperiodic_count exp %0d got %0d", e.aperiodic_count,
                       got.aperiodic_count);
                errors++;
            end
            if (got.overdue_total !== e.overdue_total)
            begin
                $error("overdue_total exp %0d got %0d", e.overdue_total, got.overdue_total);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last exp %0d got %0d", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    req_t       in_data;
    logic       out_valid;
    logic       out_ready;
    res_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_data;

    sched_scoreboard sb;
    int          idle_max;
    int          requests_sent;
    int          quiet_cycles;
    logic [31:0] tick;

    edf_task_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic req_t make_req(logic [1:0] f, logic [7:0] id, logic [31:0] rel,
                                      logic da, logic [31:0] t);
        req_t r;
        r.func          = f;
        r.task_id       = id;
        r.rel_deadline  = rel;
        r.del_aperiodic = da;
        r.now           = t;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_request(r);
        requests_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_res.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_limit(input logic [2:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sb.set_limit(v);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int          sel;
        logic [1:0]  f;
        logic [7:0]  id;
        logic [31:0] rel;
        sel = $urandom_range(0, 99);
        id  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
        if ($urandom_range(0, 15) == 0)
            tick = $urandom;
        else
            tick = tick + $urandom_range(0, 20);
        if ($urandom_range(0, 9) == 0)
            rel = $urandom;
        else if ($urandom_range(0, 3) == 0)
            rel = 0;
        else
            rel = $urandom_range(1, 60);
        if (sel < 50)
            f = FUNC_CREATE;
        else if (sel < 78)
            f = FUNC_DELETE;
        else if (sel < 95)
            f = FUNC_POLL;
        else
            f = 2'd3;
        send_request(make_req(f, id, rel, 1'($urandom), tick));
    endtask

    // receiver with random backpressure and one long hold-off
    initial
    begin
        int  w;
        bit  held;
        held = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && sb.results >= 60)
            begin
                held = 1;
                w = 300;
            end
            else
                w = $urandom_range(0, idle_max);
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            sb.check_result(out_data);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] limits[6];
        sb = new();
        limits = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd2, 3'd3};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet_cycles = 0;
        requests_sent = 0;
        idle_max = 4;
        tick = 100;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset limit
        send_request(make_req(FUNC_POLL, 8'd0, 32'd0, 1'b0, 32'd0));
        send_request(make_req(FUNC_CREATE, 8'd0, 32'd0, 1'b0, 32'd0));
        send_request(make_req(FUNC_CREATE, 8'd255, 32'd0, 1'b1, 32'd0));
        send_request(make_req(FUNC_CREATE, 8'd7, 32'd0, 1'b0, 32'd0));
        send_request(make_req(FUNC_CREATE, 8'd9, 32'd0, 1'b0, 32'd0));
        send_request(make_req(FUNC_DELETE, 8'd255, 32'd0, 1'b1, 32'd0));
        send_request(make_req(FUNC_DELETE, 8'd99, 32'd0, 1'b1, 32'd0));
        send_request(make_req(FUNC_CREATE, 8'd200, 32'hFFFF_FFFF, 1'b0, 32'd0));
        send_request(make_req(FUNC_CREATE, 8'd1, 32'hFFFF_FFFF, 1'b0, 32'd100));
        for (int k = 0; k < 8; k++)
            send_request(make_req(FUNC_CREATE, 8'(2 + k % 4), 32'(5 + 10 * (k % 3)),
                                  1'b0, 32'd100));
        send_request(make_req(FUNC_DELETE, 8'd2, 32'd0, 1'b0, 32'd100));
        send_request(make_req(FUNC_DELETE, 8'd77, 32'd0, 1'b0, 32'd100));
        send_request(make_req(2'd3, 8'd0, 32'd0, 1'b0, 32'd200));
        send_request(make_req(FUNC_DELETE, 8'd200, 32'd0, 1'b0, 32'hFFFF_FFFF));
        send_request(make_req(FUNC_POLL, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
        wait_idle();

        tick = 300;
        for (int p = 0; p < 6; p++)
        begin
            write_limit(limits[p]);
            idle_max = (p == 2) ? 0 : 4;
            for (int i = 0; i < 44; i++)
                random_request();
            wait_idle();
        end

        $display("%0d requests over limits 0..7, %0d results checked, %0d overdue",
                 requests_sent, sb.results, sb.overdue_cnt);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+design
design/edf_pkg.sv
design/edf_ram.sv
design/edf_task_scheduler.sv
tb/tb.sv
